// File: hdl/ipsp_pkg.sv
// Package for the IPS patch stream parser: field widths, result and error codes,
// parse phase types, the result record and the header byte table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ipsp_pkg;

    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned LEN_W   = 25;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned SEEN_W  = 4;

    localparam logic [SEEN_W-1:0] MIN_STREAM = 4'd8;
    localparam logic [ADDR_W-1:0] EOF_MARK   = 24'h454F46;
    localparam logic [CNT_W-1:0]  HDR_LAST   = 3'd4;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_OK    = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_HEADER    = 2'd1,
        ERR_TRUNCATED = 2'd2,
        ERR_FOOTER    = 2'd3
    } err_t;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_OFFSET = 6'b000010,
        PH_SIZE   = 6'b000100,
        PH_RUNLEN = 6'b001000,
        PH_RUNVAL = 6'b010000,
        PH_DATA   = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        EE_RUNNING = 3'b001,
        EE_BADHDR  = 3'b010,
        EE_EOFSEEN = 3'b100
    } ee_t;

    typedef struct packed {
        kind_t              kind;
        logic [ADDR_W-1:0]  address;
        logic [BYTE_W-1:0]  value;
        logic [SIZE_W-1:0]  run_length;
        logic [LEN_W-1:0]   new_length;
        err_t               error_code;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [FCNT_W-1:0] count;
        logic              empty;
        logic              no_room;
    } fifo_status_t;

    function automatic logic [BYTE_W-1:0] header_char(input logic [CNT_W-1:0] idx);
        logic [BYTE_W-1:0] c;
        c = 8'h00;
        unique case (idx)
            3'd0:    c = 8'h50;
            3'd1:    c = 8'h41;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h43;
            3'd4:    c = 8'h48;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ipsp_parser.sv
// Parse state of the IPS stream and the per-byte update that yields up to two results.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_parser (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         step,
    input  wire logic [ipsp_pkg::BYTE_W-1:0]  patch_byte,
    input  wire logic                         final_byte,
    input  wire logic [ipsp_pkg::ADDR_W-1:0]  base_length,
    output ipsp_pkg::result_t [1:0]           slots,
    output logic [1:0]                        num_results
);

    ipsp_pkg::phase_t              phase_reg, phase_next;
    ipsp_pkg::ee_t                 ee_reg, ee_next;
    logic [ipsp_pkg::CNT_W-1:0]    fc_reg, fc_next;
    logic [ipsp_pkg::ADDR_W-1:0]   ro_reg, ro_next;
    logic [ipsp_pkg::SIZE_W-1:0]   rs_reg, rs_next;
    logic [ipsp_pkg::SIZE_W-1:0]   bl_reg, bl_next;
    logic [ipsp_pkg::ADDR_W-1:0]   wa_reg, wa_next;
    logic [ipsp_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [ipsp_pkg::ADDR_W-1:0]   tail_reg, tail_next;
    logic [ipsp_pkg::SEEN_W-1:0]   seen_reg, seen_next;

    logic [ipsp_pkg::LEN_W-1:0]    len_cur;
    logic [ipsp_pkg::SIZE_W-1:0]   addend;
    logic [ipsp_pkg::LEN_W-1:0]    end_sum;
    logic [ipsp_pkg::SIZE_W-1:0]   bl_dec;
    logic                          op_valid;
    ipsp_pkg::result_t             op_res;
    ipsp_pkg::result_t             st_res;
    ipsp_pkg::err_t                err;

    always_comb
    begin
        len_cur   = (seen_reg == '0) ? {1'b0, base_length} : len_reg;
        seen_next = (seen_reg < ipsp_pkg::MIN_STREAM) ? seen_reg + 4'd1 : seen_reg;
        tail_next = {tail_reg[15:0], patch_byte};

        phase_next = phase_reg;
        ee_next    = ee_reg;
        fc_next    = fc_reg;
        ro_next    = ro_reg;
        rs_next    = rs_reg;
        bl_next    = bl_reg;
        wa_next    = wa_reg;
        len_next   = len_cur;
        bl_dec     = bl_reg - 16'd1;

        addend  = (phase_reg == ipsp_pkg::PH_SIZE) ? {rs_reg[7:0], patch_byte} : bl_reg;
        end_sum = {1'b0, ro_reg} + {9'd0, addend};

        op_valid = 1'b0;
        op_res   = '0;

        if (ee_reg == ipsp_pkg::EE_RUNNING)
        begin
            unique case (phase_reg)
                ipsp_pkg::PH_HEADER:
                begin
                    if (fc_reg > ipsp_pkg::HDR_LAST ||
                        patch_byte != ipsp_pkg::header_char(fc_reg))
                    begin
                        ee_next = ipsp_pkg::EE_BADHDR;
                    end
                    else if (fc_reg == ipsp_pkg::HDR_LAST)
                    begin
                        phase_next = ipsp_pkg::PH_OFFSET;
                        fc_next    = '0;
                        ro_next    = '0;
                    end
                    else
                    begin
                        fc_next = fc_reg + 3'd1;
                    end
                end
                ipsp_pkg::PH_OFFSET:
                begin
                    ro_next = {ro_reg[15:0], patch_byte};
                    fc_next = fc_reg + 3'd1;
                    if (fc_reg >= 3'd2)
                    begin
                        fc_next = '0;
                        if (ro_next == ipsp_pkg::EOF_MARK)
                        begin
                            ee_next = ipsp_pkg::EE_EOFSEEN;
                        end
                        else
                        begin
                            phase_next = ipsp_pkg::PH_SIZE;
                            rs_next    = '0;
                        end
                    end
                end
                ipsp_pkg::PH_SIZE:
                begin
                    rs_next = {rs_reg[7:0], patch_byte};
                    fc_next = fc_reg + 3'd1;
                    if (fc_reg >= 3'd1)
                    begin
                        fc_next = '0;
                        if (rs_next != '0)
                        begin
                            if (end_sum > len_cur)
                            begin
                                len_next = end_sum;
                            end
                            bl_next    = rs_next;
                            wa_next    = ro_reg;
                            phase_next = ipsp_pkg::PH_DATA;
                        end
                        else
                        begin
                            bl_next    = '0;
                            phase_next = ipsp_pkg::PH_RUNLEN;
                        end
                    end
                end
                ipsp_pkg::PH_RUNLEN:
                begin
                    bl_next = {bl_reg[7:0], patch_byte};
                    fc_next = fc_reg + 3'd1;
                    if (fc_reg >= 3'd1)
                    begin
                        fc_next    = '0;
                        phase_next = ipsp_pkg::PH_RUNVAL;
                    end
                end
                ipsp_pkg::PH_RUNVAL:
                begin
                    if (end_sum > len_cur)
                    begin
                        len_next = end_sum;
                    end
                    op_valid           = 1'b1;
                    op_res.kind        = ipsp_pkg::KIND_FILL;
                    op_res.address     = ro_reg;
                    op_res.value       = patch_byte;
                    op_res.run_length  = bl_reg;
                    op_res.new_length  = len_next;
                    op_res.error_code  = ipsp_pkg::ERR_NONE;
                    phase_next         = ipsp_pkg::PH_OFFSET;
                    fc_next            = '0;
                    ro_next            = '0;
                end
                ipsp_pkg::PH_DATA:
                begin
                    op_valid           = 1'b1;
                    op_res.kind        = ipsp_pkg::KIND_WRITE;
                    op_res.address     = wa_reg;
                    op_res.value       = patch_byte;
                    op_res.run_length  = '0;
                    op_res.new_length  = len_cur;
                    op_res.error_code  = ipsp_pkg::ERR_NONE;
                    wa_next            = wa_reg + 24'd1;
                    bl_next            = bl_dec;
                    if (bl_dec == '0)
                    begin
                        phase_next = ipsp_pkg::PH_OFFSET;
                        fc_next    = '0;
                        ro_next    = '0;
                    end
                end
                default:
                begin
                    phase_next = ipsp_pkg::PH_HEADER;
                end
            endcase
        end

        priority if (seen_next < ipsp_pkg::MIN_STREAM)
            err = ipsp_pkg::ERR_FOOTER;
        else if (ee_next == ipsp_pkg::EE_BADHDR)
            err = ipsp_pkg::ERR_HEADER;
        else if (tail_next != ipsp_pkg::EOF_MARK)
            err = ipsp_pkg::ERR_FOOTER;
        else if (ee_next == ipsp_pkg::EE_EOFSEEN)
            err = ipsp_pkg::ERR_NONE;
        else if (phase_next == ipsp_pkg::PH_OFFSET && fc_next == '0)
            err = ipsp_pkg::ERR_FOOTER;
        else
            err = ipsp_pkg::ERR_TRUNCATED;

        st_res             = '0;
        st_res.kind        = (err == ipsp_pkg::ERR_NONE) ? ipsp_pkg::KIND_OK
                                                         : ipsp_pkg::KIND_ERROR;
        st_res.new_length  = len_next;
        st_res.error_code  = err;
        st_res.last_of_run = 1'b1;

        op_res.last_of_run = !final_byte;

        slots[1] = st_res;
        if (op_valid)
        begin
            slots[0] = op_res;
        end
        else
        begin
            slots[0] = st_res;
        end
        num_results = step ? ({1'b0, op_valid} + {1'b0, final_byte}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ipsp_pkg::PH_HEADER;
            ee_reg    <= ipsp_pkg::EE_RUNNING;
            fc_reg    <= '0;
            ro_reg    <= '0;
            rs_reg    <= '0;
            bl_reg    <= '0;
            wa_reg    <= '0;
            len_reg   <= '0;
            tail_reg  <= '0;
            seen_reg  <= '0;
        end
        else if (step)
        begin
            if (final_byte)
            begin
                phase_reg <= ipsp_pkg::PH_HEADER;
                ee_reg    <= ipsp_pkg::EE_RUNNING;
                fc_reg    <= '0;
                ro_reg    <= '0;
                rs_reg    <= '0;
                bl_reg    <= '0;
                wa_reg    <= '0;
                len_reg   <= '0;
                tail_reg  <= '0;
                seen_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                ee_reg    <= ee_next;
                fc_reg    <= fc_next;
                ro_reg    <= ro_next;
                rs_reg    <= rs_next;
                bl_reg    <= bl_next;
                wa_reg    <= wa_next;
                len_reg   <= len_next;
                tail_reg  <= tail_next;
                seen_reg  <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/ipsp_out_fifo.sv
// Result queue of the IPS parser: takes up to two results a cycle, hands out one.
// Depends on ipsp_pkg.
`default_nettype none

module ipsp_out_fifo (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  ipsp_pkg::result_t [1:0]       push_data,
    input  wire logic [1:0]               push_count,
    input  wire logic                     pop,
    output ipsp_pkg::result_t             head,
    output ipsp_pkg::fifo_status_t        status
);

    ipsp_pkg::result_t                 entry_reg [ipsp_pkg::FIFO_DEPTH];
    logic [ipsp_pkg::PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [ipsp_pkg::PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [ipsp_pkg::FCNT_W-1:0]       count_reg, count_next;
    logic [ipsp_pkg::PTR_W-1:0]        wr_ptr_plus;
    logic                              do_pop;

    always_comb
    begin
        do_pop      = pop && (count_reg != '0);
        wr_ptr_plus = wr_ptr_reg + ipsp_pkg::PTR_W'(1);
        wr_ptr_next = wr_ptr_reg + push_count[ipsp_pkg::PTR_W-1:0];
        rd_ptr_next = do_pop ? rd_ptr_reg + ipsp_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + ipsp_pkg::FCNT_W'(push_count)
                      - ipsp_pkg::FCNT_W'(do_pop);

        head           = entry_reg[rd_ptr_reg];
        status.count   = count_reg;
        status.empty   = (count_reg == '0);
        status.no_room = (count_reg > ipsp_pkg::FCNT_W'(ipsp_pkg::FIFO_DEPTH - 2));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_count == 2'd2)
        begin
            entry_reg[wr_ptr_plus] <= push_data[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ips_patch_stream_parser_core.sv
// Top level of the IPS patch stream parser: configuration register, parser and result queue.
// Depends on ipsp_pkg, ipsp_parser and ipsp_out_fifo.
//
//   Channel   Direction  Handshake              Payload
//   patch     in         patch_valid/stall      patch_byte, final_byte
//   result    out        result_valid/stall     kind, address, value, run_length,
//                                               new_length, error_code, last_of_run
//   cfg       in         cfg_valid/cfg_ready    cfg_data (base_length)
//
// One patch byte is taken per cycle while patch_stall is low; its results enter a
// four-entry queue at the same edge and the first of them can be taken in the next cycle.
// A byte yields up to two results, so output drains at one result per cycle while
// result_stall is low, and a burst of final bytes is limited by that single output port.
// Input stalls while the queue holds more than two results; there is no clearing pass.
// Reset returns the parser to the header phase and clears base_length to zero.
`default_nettype none

module ips_patch_stream_parser_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         patch_valid,
    output logic                              patch_stall,
    input  wire logic [ipsp_pkg::BYTE_W-1:0]  patch_byte,
    input  wire logic                         final_byte,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic [1:0]                        kind,
    output logic [ipsp_pkg::ADDR_W-1:0]       address,
    output logic [ipsp_pkg::BYTE_W-1:0]       value,
    output logic [ipsp_pkg::SIZE_W-1:0]       run_length,
    output logic [ipsp_pkg::LEN_W-1:0]        new_length,
    output logic [1:0]                        error_code,
    output logic                              last_of_run,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ipsp_pkg::ADDR_W-1:0]  cfg_data
);

    logic [ipsp_pkg::ADDR_W-1:0]  base_length_reg;
    logic                         step;
    ipsp_pkg::result_t [1:0]      slots;
    logic [1:0]                   num_results;
    ipsp_pkg::result_t            head;
    ipsp_pkg::fifo_status_t       fifo_status;

    assign cfg_ready   = 1'b1;
    assign patch_stall = fifo_status.no_room;
    assign step        = patch_valid && !patch_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_length_reg <= cfg_data;
        end
    end

    ipsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .patch_byte  (patch_byte),
        .final_byte  (final_byte),
        .base_length (base_length_reg),
        .slots       (slots),
        .num_results (num_results)
    );

    ipsp_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (slots),
        .push_count (num_results),
        .pop        (result_valid && !result_stall),
        .head       (head),
        .status     (fifo_status)
    );

    assign result_valid = !fifo_status.empty;
    assign kind         = head.kind;
    assign address      = head.address;
    assign value        = head.value;
    assign run_length   = head.run_length;
    assign new_length   = head.new_length;
    assign error_code   = head.error_code;
    assign last_of_run  = head.last_of_run;

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (patch_valid && !patch_stall && final_byte) |=> result_valid)
        else $error("final byte transaction left no result queued");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !last_of_run) |=> result_valid)
        else $error("second result of a byte missing after the first was taken");

    a_ok_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == ipsp_pkg::KIND_OK) |->
        (error_code == ipsp_pkg::ERR_NONE && last_of_run))
        else $error("finished result carries an error code or is not last");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_status.count <= ipsp_pkg::FCNT_W'(ipsp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire
